// ----- design/keyframe_vec3_sampler_core_macros.svh -----
// ----------------------------------------------------------------------------
// keyframe_vec3_sampler_core assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_VEC3_SAMPLER_CORE_MACROS_SVH
`define KEYFRAME_VEC3_SAMPLER_CORE_MACROS_SVH

// same-cycle implication
`define KVS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KVS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/kvs_pkg.sv -----
// ----------------------------------------------------------------------------
// kvs_pkg
// Types and constants shared by the keyframe vec3 sampler.
// ----------------------------------------------------------------------------
package kvs_pkg;

  localparam int unsigned DEFAULT_MAX_KEYS = 64;
  localparam int unsigned KEY_COUNT_W      = 7;
  localparam int unsigned SLOT_W           = 6;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned FRAC_W           = 16;
  localparam int unsigned BLEND_W          = 17;

  localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET = 7'd1;
  localparam logic [BLEND_W-1:0]     BLEND_ONE       = 17'h10000;
  localparam logic [BLEND_W-1:0]     BLEND_ZERO      = 17'h00000;

  typedef enum logic [0:0] {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_CALC,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    op_e                      op;
    logic [SLOT_W-1:0]        key_slot;
    logic [DATA_W-1:0]        key_time;
    logic signed [DATA_W-1:0] key_x;
    logic signed [DATA_W-1:0] key_y;
    logic signed [DATA_W-1:0] key_z;
    logic [DATA_W-1:0]        sample_time;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic [SLOT_W-1:0]        segment_start;
    logic [BLEND_W-1:0]       blend_factor;
  } out_item_t;

endpackage

// ----- design/kvs_key_mem.sv -----
// ----------------------------------------------------------------------------
// kvs_key_mem
// Key table: timestamp memory and vector memory, one write and one
// registered read port each, sharing the addresses.
// ----------------------------------------------------------------------------
module kvs_key_mem #(
  parameter int unsigned MAX_KEYS = kvs_pkg::DEFAULT_MAX_KEYS
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [$clog2(MAX_KEYS)-1:0]   wr_addr_i,
  input  logic [kvs_pkg::DATA_W-1:0]    wr_stamp_i,
  input  kvs_pkg::vec3_t                wr_vec_i,
  input  logic [$clog2(MAX_KEYS)-1:0]   rd_addr_i,
  output logic [kvs_pkg::DATA_W-1:0]    rd_stamp_o,
  output kvs_pkg::vec3_t                rd_vec_o
);
  import kvs_pkg::*;

  logic [DATA_W-1:0] stamp_mem [MAX_KEYS];
  vec3_t             vec_mem   [MAX_KEYS];
  logic [DATA_W-1:0] rd_stamp_q;
  vec3_t             rd_vec_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      stamp_mem[wr_addr_i] <= wr_stamp_i;
      vec_mem[wr_addr_i]   <= wr_vec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_stamp_q <= stamp_mem[rd_addr_i];
    rd_vec_q   <= vec_mem[rd_addr_i];
  end

  assign rd_stamp_o = rd_stamp_q;
  assign rd_vec_o   = rd_vec_q;

endmodule

// ----- design/kvs_frac_div.sv -----
// ----------------------------------------------------------------------------
// kvs_frac_div
// Restoring divider for the blend fraction: quo = (num << 16) / den,
// valid when num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kvs_frac_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [kvs_pkg::DATA_W-1:0]   num_i,
  input  logic [kvs_pkg::DATA_W-1:0]   den_i,
  output logic                         done_o,
  output logic [kvs_pkg::FRAC_W-1:0]   quo_o
);
  import kvs_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAC_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic [DATA_W-1:0] den_q, den_d;
  logic [FRAC_W-1:0] quo_q, quo_d;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;

  always_comb begin
    // remainder stays below den, so the shifted value fits in 33 bits
    shifted = {rem_q, 1'b0};
    trial   = shifted - {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      if (!trial[DATA_W]) begin
        rem_d = trial[DATA_W-1:0];
        quo_d = {quo_q[FRAC_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DATA_W-1:0];
        quo_d = {quo_q[FRAC_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(FRAC_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- design/keyframe_vec3_sampler_core.sv -----
// ----------------------------------------------------------------------------
// keyframe_vec3_sampler_core
// Keyframe table with linear interpolation of an xyz Q16.16 vector.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid_i/cfg_ready_o/cfg_data_i) sets key_count; it is always
//   ready and must only be written while the block is idle. in channel: op = write
//   stores a key into a slot and gives no result; op = sample returns one
//   out transaction with the vector, the segment start index and the blend factor.
//   A sample scans s keys (1 to key_count - 1), one timestamp read per cycle on the
//   single read port, then reads both segment ends (RD_A, RD_B, RD_C), decides the
//   factor in CALC, runs the 16-step serial divider when the sample time lies at or
//   after the segment start and less than the segment gap past it, and does the lerp
//   on one shared multiplier (MUL then ADD for each of x, y, z). The result is
//   registered in DONE, and the next item can be taken in the cycle after; with a
//   single key the scan and the divider are skipped. A stalled receiver holds the
//   result; the next item is still taken, and the next sample waits in its last state.
//   Reset sets key_count to 1 and empties the output register; the key table is
//   not cleared and must be written before it is sampled.
// ----------------------------------------------------------------------------
`include "keyframe_vec3_sampler_core_macros.svh"

module keyframe_vec3_sampler_core #(
  parameter int unsigned MAX_KEYS = kvs_pkg::DEFAULT_MAX_KEYS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kvs_pkg::KEY_COUNT_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  kvs_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output kvs_pkg::out_item_t                out_data_o
);
  import kvs_pkg::*;

  localparam int unsigned IW = $clog2(MAX_KEYS);
  localparam int unsigned NW = IW + 1;

  state_e                 state_q, state_d;
  logic [KEY_COUNT_W-1:0] key_count_q;
  logic [DATA_W-1:0]      t_q, t_d;
  logic [NW-1:0]          n_q, n_d;
  logic [IW-1:0]          k_q, k_d;
  logic [IW-1:0]          seg_q, seg_d;
  logic [IW-1:0]          nx_q, nx_d;
  logic                   single_q, single_d;
  logic [DATA_W-1:0]      ts_q, ts_d;
  logic [DATA_W-1:0]      tn_q, tn_d;
  vec3_t                  va_q, va_d;
  vec3_t                  vb_q, vb_d;
  logic [BLEND_W-1:0]     f_q, f_d;
  logic [1:0]             comp_q, comp_d;
  logic signed [50:0]     prod_q, prod_d;
  vec3_t                  res_q, res_d;
  out_item_t              out_data_q, out_data_d;
  logic                   out_valid_q, out_valid_d;

  logic                   in_take;
  logic                   mem_wr_en;
  logic                   slot_ok;
  logic [IW-1:0]          rd_addr;
  logic [DATA_W-1:0]      rd_stamp;
  vec3_t                  rd_vec;
  logic [NW-1:0]          n_eff;
  logic [NW-1:0]          k_ext;
  logic [DATA_W-1:0]      gap;
  logic [DATA_W-1:0]      num;
  logic                   div_start;
  logic                   div_done;
  logic [FRAC_W-1:0]      div_quo;
  logic                   out_load;
  logic signed [DATA_W-1:0] a_c, b_c, sum_c;
  logic signed [DATA_W:0]   diff_c;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_take     = in_valid_i & in_ready_o;
  assign slot_ok     = (int'(in_data_i.key_slot) < MAX_KEYS);
  assign mem_wr_en   = in_take & (in_data_i.op == OP_WRITE) & slot_ok;
  assign k_ext       = {1'b0, k_q};

  // key count as used by a sample: zero means one, clamp to table depth
  always_comb begin
    if (key_count_q == '0) begin
      n_eff = NW'(1);
    end else if (int'(key_count_q) > MAX_KEYS) begin
      n_eff = NW'(MAX_KEYS);
    end else begin
      n_eff = NW'(key_count_q);
    end
  end

  kvs_key_mem #(
    .MAX_KEYS (MAX_KEYS)
  ) u_key_mem (
    .clk_i      (clk_i),
    .wr_en_i    (mem_wr_en),
    .wr_addr_i  (IW'(in_data_i.key_slot)),
    .wr_stamp_i (in_data_i.key_time),
    .wr_vec_i   ({in_data_i.key_x, in_data_i.key_y, in_data_i.key_z}),
    .rd_addr_i  (rd_addr),
    .rd_stamp_o (rd_stamp),
    .rd_vec_o   (rd_vec)
  );

  kvs_frac_div u_frac_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (gap),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // lerp lane select
  always_comb begin
    unique case (comp_q)
      2'd0: begin
        a_c = va_q.x;
        b_c = vb_q.x;
      end
      2'd1: begin
        a_c = va_q.y;
        b_c = vb_q.y;
      end
      default: begin
        a_c = va_q.z;
        b_c = vb_q.z;
      end
    endcase
  end

  assign diff_c = (DATA_W+1)'(b_c) - (DATA_W+1)'(a_c);
  // floor of prod / 65536, added modulo 2^32
  assign sum_c  = a_c + prod_q[47:16];
  assign gap    = (tn_q >= ts_q) ? (tn_q - ts_q) : (ts_q - tn_q);
  assign num    = t_q - ts_q;

  always_comb begin
    state_d    = state_q;
    t_d        = t_q;
    n_d        = n_q;
    k_d        = k_q;
    seg_d      = seg_q;
    nx_d       = nx_q;
    single_d   = single_q;
    ts_d       = ts_q;
    tn_d       = tn_q;
    va_d       = va_q;
    vb_d       = vb_q;
    f_d        = f_q;
    comp_d     = comp_q;
    prod_d     = prod_q;
    res_d      = res_q;
    out_data_d = out_data_q;
    rd_addr    = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_take && (in_data_i.op == OP_SAMPLE)) begin
          t_d = in_data_i.sample_time;
          n_d = n_eff;
          if (n_eff == NW'(1)) begin
            single_d = 1'b1;
            seg_d    = '0;
            nx_d     = '0;
            state_d  = ST_RD_A;
          end else begin
            single_d = 1'b0;
            rd_addr  = IW'(1);
            k_d      = IW'(1);
            state_d  = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // rd_stamp holds stamp[k]; the read of stamp[k+1] goes out meanwhile
        rd_addr = k_q + 1'b1;
        if (t_q < rd_stamp) begin
          seg_d   = k_q - 1'b1;
          nx_d    = k_q;
          state_d = ST_RD_A;
        end else if (k_ext == n_q - 1'b1) begin
          seg_d   = k_q;
          nx_d    = '0;
          state_d = ST_RD_A;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_RD_A: begin
        rd_addr = seg_q;
        state_d = ST_RD_B;
      end
      ST_RD_B: begin
        rd_addr = nx_q;
        ts_d    = rd_stamp;
        va_d    = rd_vec;
        state_d = ST_RD_C;
      end
      ST_RD_C: begin
        tn_d    = rd_stamp;
        vb_d    = rd_vec;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        comp_d  = 2'd0;
        state_d = ST_MUL;
        if (single_q) begin
          f_d = BLEND_ZERO;
        end else if (gap == '0) begin
          f_d = BLEND_ONE;
        end else if (t_q < ts_q) begin
          f_d = BLEND_ZERO;
        end else if (num >= gap) begin
          f_d = BLEND_ONE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          f_d     = {1'b0, div_quo};
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = $signed({1'b0, f_q}) * diff_c;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        unique case (comp_q)
          2'd0:    res_d.x = sum_c;
          2'd1:    res_d.y = sum_c;
          default: res_d.z = sum_c;
        endcase
        if (comp_q == 2'd2) begin
          state_d = ST_DONE;
        end else begin
          comp_d  = comp_q + 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load                 = 1'b1;
          out_data_d.out_x         = res_q.x;
          out_data_d.out_y         = res_q.y;
          out_data_d.out_z         = res_q.z;
          out_data_d.segment_start = SLOT_W'(seg_q);
          out_data_d.blend_factor  = f_q;
          state_d                  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_count_q <= KEY_COUNT_RESET;
      out_valid_q <= 1'b0;
      comp_q      <= 2'd0;
      single_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      comp_q      <= comp_d;
      single_q    <= single_d;
      if (cfg_valid_i && cfg_ready_o) begin
        key_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q        <= t_d;
    n_q        <= n_d;
    k_q        <= k_d;
    seg_q      <= seg_d;
    nx_q       <= nx_d;
    ts_q       <= ts_d;
    tn_q       <= tn_d;
    va_q       <= va_d;
    vb_q       <= vb_d;
    f_q        <= f_d;
    prod_q     <= prod_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `KVS_ASSERT_IMP(a_wr_only_idle, mem_wr_en, state_q == ST_IDLE,
                  "key write outside idle")
  `KVS_ASSERT_IMP(a_load_slot_free, out_load, !out_valid_q || out_ready_i,
                  "result overwrites a pending transaction")
  `KVS_ASSERT_IMP(a_blend_range, out_valid_q, out_data_q.blend_factor <= BLEND_ONE,
                  "blend factor above one")
  `KVS_ASSERT_IMP(a_div_done_state, div_done, state_q == ST_DIV,
                  "divider finished outside divide state")
  `KVS_ASSERT_IMP(a_scan_range, state_q == ST_SCAN, k_ext < n_q,
                  "key scan beyond key count")
  `KVS_ASSERT_NXT(a_div_start_wait, div_start, state_q == ST_DIV,
                  "divide started without waiting")

endmodule
